### rtl/spkct_pkg.sv
package spkct_pkg;

    typedef enum logic [3:0] {
        CMD_STAGE        = 4'd0,
        CMD_STAGE_TRANSP = 4'd1,
        CMD_GET          = 4'd2,
        CMD_GET_TRANSP   = 4'd3,
        CMD_LIVE_TRANSP  = 4'd4,
        CMD_CLEAR        = 4'd5,
        CMD_CLEAR_STAGED = 4'd6,
        CMD_FILL         = 4'd7,
        CMD_COMMIT       = 4'd8,
        CMD_DISCARD      = 4'd9,
        CMD_RESET        = 4'd10
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LAYER = 2'd1;
    localparam logic [1:0] ST_BAD_KEY   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [3:0]  cmd;
        logic [1:0]  status;
        logic [7:0]  layer;
        logic [7:0]  key;
        logic [31:0] color;
        logic        tin;
    } job_t;

endpackage

### rtl/spkct_ram.sv
module spkct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/spkct_front.sv
module spkct_front
    import spkct_pkg::*;
#(
    parameter int LAYER_COUNT = 8,
    parameter int KEY_COUNT   = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [7:0]  s_layer,
    input  logic [7:0]  s_key,
    input  logic [31:0] s_color_in,
    input  logic        s_transparent_in,
    output logic        q_valid,
    input  logic        q_ready,
    output job_t        q_job
);
    // Two-entry queue between classification and execution.
    job_t       q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    job_t       job;
    logic       push, pop;

    always_comb begin
        job.cmd    = s_cmd;
        job.layer  = s_layer;
        job.key    = s_key;
        job.color  = s_color_in;
        job.tin    = s_transparent_in;
        job.status = ST_OK;
        if (s_cmd <= CMD_FILL && {1'b0, s_layer} >= 9'(LAYER_COUNT)) begin
            job.status = ST_BAD_LAYER;
        end else if ((s_cmd == CMD_STAGE || s_cmd == CMD_GET)
                     && {1'b0, s_key} >= 9'(KEY_COUNT)) begin
            job.status = ST_BAD_KEY;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_job   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                q_mem_reg[wr_ptr_reg] <= job;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### rtl/spkct_back.sv
module spkct_back
    import spkct_pkg::*;
#(
    parameter int LAYER_COUNT = 8,
    parameter int KEY_COUNT   = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  job_t        q_job,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_color_out,
    output logic        m_transparent_out
);
    localparam int LW    = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
    localparam int KW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int AW    = LW + KW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_FILL, S_COMMIT_RD, S_COMMIT_WR, S_OUT
    } state_t;

    state_t state_reg;
    job_t   job_reg;
    logic [KEY_COUNT-1:0] live_v_reg   [LAYER_COUNT];
    logic [KEY_COUNT-1:0] staged_v_reg [LAYER_COUNT];
    logic [LAYER_COUNT-1:0] live_t_reg, staged_t_reg, dirty_reg;
    logic [LW-1:0] l_reg;
    logic [KW-1:0] k_reg;
    logic [AW-1:0] walk_a_reg;
    logic          walk_hit_reg;
    logic [1:0]    status_reg;
    logic [31:0]   color_reg;
    logic          tout_reg;

    logic          s_we, l_we;
    logic [AW-1:0] s_waddr, l_waddr, s_raddr, l_raddr;
    logic [31:0]   s_wdata, s_rdata, l_rdata;

    logic [AW-1:0] walk_a;
    logic [LW-1:0] walk_l;
    logic [KW-1:0] walk_k;
    logic [LW-1:0] jl;
    logic [KW-1:0] jk;
    logic          last_key, last_layer;

    assign jl = job_reg.layer[LW-1:0];
    assign jk = job_reg.key[KW-1:0];
    assign walk_a = {l_reg, k_reg};
    assign last_key   = ({1'b0, k_reg} == (KW+1)'(KEY_COUNT - 1));
    assign last_layer = ({1'b0, l_reg} == (LW+1)'(LAYER_COUNT - 1));
    assign walk_l = walk_a_reg[AW-1:KW];
    assign walk_k = walk_a_reg[KW-1:0];

    always_comb begin
        s_we    = 1'b0;
        s_waddr = {jl, k_reg};
        s_wdata = job_reg.color;
        l_we    = 1'b0;
        l_waddr = walk_a_reg;
        s_raddr = {jl, jk};
        l_raddr = {jl, jk};
        if (state_reg == S_READ && job_reg.cmd == CMD_STAGE) begin
            s_we    = 1'b1;
            s_waddr = {jl, jk};
        end
        if (state_reg == S_FILL) begin
            s_we = 1'b1;
        end
        if (state_reg == S_COMMIT_RD) begin
            s_raddr = walk_a;
        end
        if (state_reg == S_COMMIT_WR && walk_hit_reg) begin
            l_we = 1'b1;
        end
    end

    spkct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_staged (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );
    spkct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_live (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(s_rdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    assign q_ready           = (state_reg == S_IDLE);
    assign m_valid           = (state_reg == S_OUT);
    assign m_status          = status_reg;
    assign m_color_out       = color_reg;
    assign m_transparent_out = tout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            live_t_reg <= '0;
            staged_t_reg <= '0;
            dirty_reg  <= '0;
            for (int i = 0; i < LAYER_COUNT; i++) begin
                live_v_reg[i]   <= '0;
                staged_v_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        job_reg    <= q_job;
                        status_reg <= q_job.status;
                        color_reg  <= '0;
                        tout_reg   <= 1'b0;
                        k_reg      <= '0;
                        l_reg      <= '0;
                        state_reg  <= (q_job.status != ST_OK) ? S_OUT : S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_OUT;
                    unique case (job_reg.cmd)
                        CMD_STAGE:        staged_v_reg[jl][jk] <= 1'b1;
                        CMD_STAGE_TRANSP: begin
                            staged_t_reg[jl] <= job_reg.tin;
                            dirty_reg[jl]    <= 1'b1;
                        end
                        CMD_GET:          state_reg <= S_WAIT;
                        CMD_GET_TRANSP:
                            tout_reg <= dirty_reg[jl] ? staged_t_reg[jl] : live_t_reg[jl];
                        CMD_LIVE_TRANSP:  tout_reg <= live_t_reg[jl];
                        CMD_CLEAR: begin
                            live_v_reg[jl]   <= '0;
                            staged_v_reg[jl] <= '0;
                        end
                        CMD_CLEAR_STAGED: staged_v_reg[jl] <= '0;
                        CMD_FILL:         state_reg <= S_FILL;
                        CMD_COMMIT:       state_reg <= S_COMMIT_RD;
                        CMD_DISCARD: begin
                            for (int i = 0; i < LAYER_COUNT; i++) begin
                                staged_v_reg[i] <= '0;
                            end
                            dirty_reg <= '0;
                        end
                        CMD_RESET: begin
                            for (int i = 0; i < LAYER_COUNT; i++) begin
                                staged_v_reg[i] <= '0;
                                live_v_reg[i]   <= '0;
                            end
                            dirty_reg  <= '0;
                            live_t_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_WAIT: begin
                    if (staged_v_reg[jl][jk]) begin
                        color_reg <= s_rdata;
                    end else if (live_v_reg[jl][jk]) begin
                        color_reg <= l_rdata;
                    end else begin
                        status_reg <= ST_NOT_FOUND;
                    end
                    state_reg <= S_OUT;
                end
                S_FILL: begin
                    staged_v_reg[jl][k_reg] <= 1'b1;
                    k_reg <= k_reg + KW'(1);
                    if (last_key) begin
                        state_reg <= S_OUT;
                    end
                end
                S_COMMIT_RD: begin
                    // Read one staged word, write it live on the next cycle.
                    walk_a_reg   <= walk_a;
                    walk_hit_reg <= staged_v_reg[l_reg][k_reg];
                    state_reg    <= S_COMMIT_WR;
                end
                S_COMMIT_WR: begin
                    if (walk_hit_reg) begin
                        live_v_reg[walk_l][walk_k] <= 1'b1;
                    end
                    if (last_key) begin
                        k_reg <= '0;
                        if (dirty_reg[l_reg]) begin
                            live_t_reg[l_reg] <= staged_t_reg[l_reg];
                        end
                        if (last_layer) begin
                            for (int i = 0; i < LAYER_COUNT; i++) begin
                                staged_v_reg[i] <= '0;
                            end
                            dirty_reg <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            l_reg     <= l_reg + LW'(1);
                            state_reg <= S_COMMIT_RD;
                        end
                    end else begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_COMMIT_RD;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/staged_per_key_color_table.sv
// Staged per-key color table.
// Input channel s_*: one command per transfer (stage, stage transparency,
// get, transparency queries, clear, clear staged, fill, commit, discard,
// reset) with layer, key, color and transparency operands.
// Result channel m_*: exactly one result per command, in order, carrying
// status, color and transparency answer.
// A front stage checks layer and key ranges and pushes the command into a
// two-entry queue; the input side keeps accepting while the queue has room.
// A back stage executes one command at a time against two color RAMs.
// Back stage steps: a bad operand goes straight to the result; other
// commands pass a read step, get adds a wait step, fill writes every key
// of the layer; commit reads each staged entry, then writes it live if staged.
// Reset (aresetn low, synchronous) clears all valid marks, transparency
// flags and dirty marks and empties the queue; color RAMs are not cleared.
// When m_ready is low the result holds and the back stage waits; the queue
// then fills and s_ready drops.
module staged_per_key_color_table
    import spkct_pkg::*;
#(
    parameter int LAYER_COUNT = 8,
    parameter int KEY_COUNT   = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [7:0]  s_layer,
    input  logic [7:0]  s_key,
    input  logic [31:0] s_color_in,
    input  logic        s_transparent_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_color_out,
    output logic        m_transparent_out
);
    logic q_valid, q_ready;
    job_t q_job;

    spkct_front #(.LAYER_COUNT(LAYER_COUNT), .KEY_COUNT(KEY_COUNT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_layer(s_layer),
        .s_key(s_key), .s_color_in(s_color_in), .s_transparent_in(s_transparent_in),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
    );

    spkct_back #(.LAYER_COUNT(LAYER_COUNT), .KEY_COUNT(KEY_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_color_out(m_color_out), .m_transparent_out(m_transparent_out)
    );
endmodule
